// File: rtl/core/rotate_point_about_pivot_defines.svh
// assertion macros for the rotate-about-pivot checker
`ifndef ROTATE_POINT_ABOUT_PIVOT_DEFINES_SVH
`define ROTATE_POINT_ABOUT_PIVOT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RPP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rotate pivot check failed");

// next-cycle implication, disabled while in reset
`define RPP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rotate pivot check failed");

// condition that must hold on the cycle after reset is seen
`define RPP_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("rotate pivot reset check failed");

`endif

// File: rtl/core/rpp_pkg.sv
// shared constants, types and tables for the point rotation pipeline
package rpp_pkg;

   // coordinate and iteration configuration
   localparam int COORD_BITS   = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 30;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   // angle split: two quarter-turn bits and a residual
   localparam int ANGLE_BITS  = 16;
   localparam int RESID_BITS  = ANGLE_BITS - 2;
   localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

   // cordic datapath, cosine and sine in q2.30
   localparam int CS_BITS = 32;
   localparam int Z_BITS  = 32;
   localparam int CS_FRAC = 30;

   // rotation datapath widths
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + CS_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int RND_BITS  = SUM_BITS - CS_FRAC;
   localparam int TOT_BITS  = RND_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [CS_BITS-1:0]    cs_type;
   typedef logic signed [Z_BITS-1:0]     z_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [RND_BITS-1:0]   rnd_type;
   typedef logic signed [TOT_BITS-1:0]   tot_type;
   typedef logic [RESID_BITS-1:0]        resid_type;
   typedef logic [ANGLE_BITS-1:0]        angle_type;

   typedef enum logic [1:0] {
      QUARTER_0 = 2'd0,
      QUARTER_1 = 2'd1,
      QUARTER_2 = 2'd2,
      QUARTER_3 = 2'd3
   } quarter_type;

   // per-point data that rides alongside the cordic stages
   typedef struct packed {
      diff_type    dx;
      diff_type    dy;
      coord_type   cx;
      coord_type   cy;
      quarter_type quarter;
   } side_type;

   // limit gain in q2.30, start vector of every rotation
   localparam cs_type GAIN_Q30 = 32'sd652032874;

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest
   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

endpackage

// File: rtl/core/rpp_if.sv
// request and response channel interfaces for the point rotation block

// request channel: point, optional pivot and angle
interface rpp_req_if;
   logic                valid;
   logic                ready;
   rpp_pkg::coord_type  point_x;
   rpp_pkg::coord_type  point_y;
   rpp_pkg::coord_type  pivot_x;
   rpp_pkg::coord_type  pivot_y;
   logic                use_pivot;
   rpp_pkg::angle_type  angle;

   modport source (
      output valid, point_x, point_y, pivot_x, pivot_y, use_pivot, angle,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, pivot_x, pivot_y, use_pivot, angle,
      output ready
   );
endinterface

// response channel: rotated point
interface rpp_rsp_if;
   logic                valid;
   logic                ready;
   rpp_pkg::coord_type  rotated_x;
   rpp_pkg::coord_type  rotated_y;

   modport source (
      output valid, rotated_x, rotated_y,
      input  ready
   );
   modport sink (
      input  valid, rotated_x, rotated_y,
      output ready
   );
endinterface

// File: rtl/core/rotate_point_about_pivot.sv
// Rotates a Q16.16 point counterclockwise by a 16-bit binary angle, about the
// origin or about a pivot. The pipeline takes one request every cycle while
// the output is not stalled, and passes each one through one input stage
// that forms the pivot offsets, one register stage per CORDIC iteration that
// produces cosine and sine, and four stages that map the quarter turn,
// multiply, round and saturate. All stages share one advance enable, so
// while a result waits at the output register the whole pipeline holds and
// no new request is taken; an empty output register always admits a request.
module rotate_point_about_pivot (
   input  logic        clock,
   input  logic        reset,
   rpp_req_if.sink     req_ch,
   rpp_rsp_if.source   rsp_ch
);

   logic               adv;
   logic               front_v_ff;
   rpp_pkg::side_type  side_in, side_ff;
   rpp_pkg::resid_type resid_ff;
   rpp_pkg::coord_type piv_x, piv_y;
   logic               cordic_valid;
   rpp_pkg::side_type  cordic_side;
   rpp_pkg::cs_type    cordic_x, cordic_y;
   logic               out_valid;

   // the pipeline moves whenever the output register is empty or drained
   assign adv          = !out_valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // front stage: pivot offsets and angle split
   assign piv_x = req_ch.use_pivot ? req_ch.pivot_x : '0;
   assign piv_y = req_ch.use_pivot ? req_ch.pivot_y : '0;

   always_comb begin
      side_in.dx      = rpp_pkg::diff_type'(req_ch.point_x) - rpp_pkg::diff_type'(piv_x);
      side_in.dy      = rpp_pkg::diff_type'(req_ch.point_y) - rpp_pkg::diff_type'(piv_y);
      side_in.cx      = piv_x;
      side_in.cy      = piv_y;
      side_in.quarter = rpp_pkg::quarter_type'(req_ch.angle[rpp_pkg::ANGLE_BITS-1 -: 2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (adv) begin
         front_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff  <= side_in;
         resid_ff <= req_ch.angle[rpp_pkg::RESID_BITS-1:0];
      end
   end

   // cosine and sine of the residual angle
   rpp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_v_ff),
      .in_side   (side_ff),
      .in_resid  (resid_ff),
      .out_valid (cordic_valid),
      .out_side  (cordic_side),
      .out_x     (cordic_x),
      .out_y     (cordic_y)
   );

   // rotation, rounding and saturation
   rpp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cordic_valid),
      .in_side   (cordic_side),
      .in_x      (cordic_x),
      .in_y      (cordic_y),
      .out_valid (out_valid),
      .rotated_x (rsp_ch.rotated_x),
      .rotated_y (rsp_ch.rotated_y)
   );

   assign rsp_ch.valid = out_valid;

endmodule

// File: rtl/core/rpp_cordic.sv
// pipelined cordic: one rotation-mode iteration per register stage
module rpp_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rpp_pkg::side_type  in_side,
   input  rpp_pkg::resid_type in_resid,
   output logic               out_valid,
   output rpp_pkg::side_type  out_side,
   output rpp_pkg::cs_type    out_x,
   output rpp_pkg::cs_type    out_y
);

   logic              v_ff    [rpp_pkg::CORDIC_ITERS];
   rpp_pkg::cs_type   x_ff    [rpp_pkg::CORDIC_ITERS];
   rpp_pkg::cs_type   y_ff    [rpp_pkg::CORDIC_ITERS];
   rpp_pkg::z_type    z_ff    [rpp_pkg::CORDIC_ITERS];
   rpp_pkg::side_type side_ff [rpp_pkg::CORDIC_ITERS];

   for (genvar i = 0; i < rpp_pkg::CORDIC_ITERS; i++) begin : g_stage
      logic              v_src;
      rpp_pkg::cs_type   x_src;
      rpp_pkg::cs_type   y_src;
      rpp_pkg::z_type    z_src;
      rpp_pkg::side_type side_src;
      rpp_pkg::cs_type   xs;
      rpp_pkg::cs_type   ys;
      rpp_pkg::cs_type   x_in;
      rpp_pkg::cs_type   y_in;
      rpp_pkg::z_type    z_in;

      // stage source: gain-scaled start vector or previous stage
      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign x_src    = rpp_pkg::GAIN_Q30;
         assign y_src    = '0;
         assign z_src    = rpp_pkg::z_type'({in_resid, {rpp_pkg::ANGLE_SHIFT{1'b0}}});
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      // one micro-rotation, direction from the sign of the residual angle
      always_comb begin
         xs = x_src >>> i;
         ys = y_src >>> i;
         if (!z_src[rpp_pkg::Z_BITS-1]) begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            z_in = z_src - rpp_pkg::z_type'(rpp_pkg::ATAN_TABLE[i]);
         end else begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            z_in = z_src + rpp_pkg::z_type'(rpp_pkg::ATAN_TABLE[i]);
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_src;
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[rpp_pkg::CORDIC_ITERS-1];
   assign out_side  = side_ff[rpp_pkg::CORDIC_ITERS-1];
   assign out_x     = x_ff[rpp_pkg::CORDIC_ITERS-1];
   assign out_y     = y_ff[rpp_pkg::CORDIC_ITERS-1];

endmodule

// File: rtl/core/rpp_rotate.sv
// quarter-turn mapping, rotation products, rounding and saturation stages
module rpp_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rpp_pkg::side_type  in_side,
   input  rpp_pkg::cs_type    in_x,
   input  rpp_pkg::cs_type    in_y,
   output logic               out_valid,
   output rpp_pkg::coord_type rotated_x,
   output rpp_pkg::coord_type rotated_y
);

   localparam rpp_pkg::sum_type ROUND_HALF = rpp_pkg::sum_type'(1) << (rpp_pkg::CS_FRAC - 1);

   // clamp to the signed coordinate range
   function automatic rpp_pkg::coord_type sat_coord(input rpp_pkg::tot_type v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[rpp_pkg::TOT_BITS-1:rpp_pkg::COORD_BITS-1];
      all_zeros = ~|v[rpp_pkg::TOT_BITS-1:rpp_pkg::COORD_BITS-1];
      if (all_ones || all_zeros) begin
         return v[rpp_pkg::COORD_BITS-1:0];
      end else if (v[rpp_pkg::TOT_BITS-1]) begin
         return {1'b1, {(rpp_pkg::COORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(rpp_pkg::COORD_BITS-1){1'b1}}};
      end
   endfunction

   // stage 0: cosine and sine for the full angle
   logic               v0_ff;
   rpp_pkg::cs_type    c_in, s_in, c_ff, s_ff;
   rpp_pkg::side_type  side0_ff;

   always_comb begin
      unique case (in_side.quarter)
         rpp_pkg::QUARTER_0: begin
            c_in = in_x;
            s_in = in_y;
         end
         rpp_pkg::QUARTER_1: begin
            c_in = -in_y;
            s_in = in_x;
         end
         rpp_pkg::QUARTER_2: begin
            c_in = -in_x;
            s_in = -in_y;
         end
         rpp_pkg::QUARTER_3: begin
            c_in = in_y;
            s_in = -in_x;
         end
         default: begin
            c_in = in_x;
            s_in = in_y;
         end
      endcase
   end

   // stage 1: the four rotation products
   logic               v1_ff;
   rpp_pkg::prod_type  pxc_in, pys_in, pyc_in, pxs_in;
   rpp_pkg::prod_type  pxc_ff, pys_ff, pyc_ff, pxs_ff;
   rpp_pkg::coord_type cx1_ff, cy1_ff;

   assign pxc_in = rpp_pkg::prod_type'(side0_ff.dx) * rpp_pkg::prod_type'(c_ff);
   assign pys_in = rpp_pkg::prod_type'(side0_ff.dy) * rpp_pkg::prod_type'(s_ff);
   assign pyc_in = rpp_pkg::prod_type'(side0_ff.dy) * rpp_pkg::prod_type'(c_ff);
   assign pxs_in = rpp_pkg::prod_type'(side0_ff.dx) * rpp_pkg::prod_type'(s_ff);

   // stage 2: combine, round half up, drop the q2.30 fraction
   logic               v2_ff;
   rpp_pkg::sum_type   sum_x, sum_y;
   rpp_pkg::rnd_type   rx_in, ry_in, rx2_ff, ry2_ff;
   rpp_pkg::coord_type cx2_ff, cy2_ff;

   assign sum_x = rpp_pkg::sum_type'(pxc_ff) - rpp_pkg::sum_type'(pys_ff) + ROUND_HALF;
   assign sum_y = rpp_pkg::sum_type'(pyc_ff) + rpp_pkg::sum_type'(pxs_ff) + ROUND_HALF;
   assign rx_in = rpp_pkg::rnd_type'(sum_x >>> rpp_pkg::CS_FRAC);
   assign ry_in = rpp_pkg::rnd_type'(sum_y >>> rpp_pkg::CS_FRAC);

   // stage 3: add the pivot back and saturate into the output register
   logic               v3_ff;
   rpp_pkg::tot_type   tot_x, tot_y;
   rpp_pkg::coord_type out_x_in, out_y_in, out_x_ff, out_y_ff;

   assign tot_x    = rpp_pkg::tot_type'(rx2_ff) + rpp_pkg::tot_type'(cx2_ff);
   assign tot_y    = rpp_pkg::tot_type'(ry2_ff) + rpp_pkg::tot_type'(cy2_ff);
   assign out_x_in = sat_coord(tot_x);
   assign out_y_in = sat_coord(tot_y);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         side0_ff <= in_side;
         pxc_ff   <= pxc_in;
         pys_ff   <= pys_in;
         pyc_ff   <= pyc_in;
         pxs_ff   <= pxs_in;
         cx1_ff   <= side0_ff.cx;
         cy1_ff   <= side0_ff.cy;
         rx2_ff   <= rx_in;
         ry2_ff   <= ry_in;
         cx2_ff   <= cx1_ff;
         cy2_ff   <= cy1_ff;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign out_valid = v3_ff;
   assign rotated_x = out_x_ff;
   assign rotated_y = out_y_ff;

endmodule

// File: rtl/core/rpp_checker.sv
// port-level checks for the point rotation block, bound to the top level
`include "rotate_point_about_pivot_defines.svh"

module rpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rpp_pkg::coord_type rotated_x,
   input rpp_pkg::coord_type rotated_y
);

   // a waiting result holds with its payload
   `RPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rotated_x) && $stable(rotated_y))

   // a stalled output freezes the pipe, so no request is taken
   `RPP_ASSERT_SAME(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)

   // an empty output register always admits a request
   `RPP_ASSERT_SAME(a_empty_takes_req, !rsp_valid, req_ready)

   // reset empties the pipeline
   `RPP_ASSERT_AFTER_RESET(a_reset_clears, !rsp_valid)

endmodule

bind rotate_point_about_pivot rpp_checker u_rpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rotated_x (rsp_ch.rotated_x),
   .rotated_y (rsp_ch.rotated_y)
);

// File: bench/testbench.sv
// self-checking testbench for the point rotation pipeline
module testbench;

   // rotation request and rotated point as the bench sees them
   typedef struct packed {
      rpp_pkg::coord_type point_x;
      rpp_pkg::coord_type point_y;
      rpp_pkg::coord_type pivot_x;
      rpp_pkg::coord_type pivot_y;
      logic               use_pivot;
      rpp_pkg::angle_type angle;
   } rot_req_type;

   typedef struct packed {
      rpp_pkg::coord_type rotated_x;
      rpp_pkg::coord_type rotated_y;
   } rot_point_type;

   typedef struct packed {
      rot_req_type   req;
      logic          known;
      rot_point_type want;
   } dir_row_type;

   typedef logic signed [95:0] wide_type;

   localparam rpp_pkg::coord_type COORD_MAX  = 32'sh7FFF_FFFF;
   localparam rpp_pkg::coord_type COORD_MIN  = 32'sh8000_0000;
   localparam int        ARC_COUNT  = 30;
   localparam int        ROT_STEPS  = (rpp_pkg::CORDIC_STEPS < ARC_COUNT) ?
                                      rpp_pkg::CORDIC_STEPS : ARC_COUNT;
   localparam longint    START_GAIN = 652032874;
   localparam wide_type  HALF_LSB   = 96'sd536870912;
   localparam int        LONG_HOLD  = 300;
   localparam int        IDLE_LIMIT = 5000;
   localparam int        RAND_ITEMS = 2000;
   localparam int        CALM_FROM  = 1700;
   localparam int        TAIL_WAIT  = 40;

   // atan(2^-i) in units of 2^-32 turn
   localparam longint ARC_TAB [ARC_COUNT] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1
   };

   logic clock;
   logic reset;

   rpp_req_if req_bus ();
   rpp_rsp_if rsp_bus ();

   rotate_point_about_pivot uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rot_point_type rotated_fifo[$];
   dir_row_type   directed[$];
   int         errors       = 0;
   int         results_seen = 0;
   int         pivot_reqs   = 0;
   int         clipped_seen = 0;
   bit         calm         = 1'b0;
   bit         long_done    = 1'b0;

   // clamp a wide value to the coordinate range
   function automatic rpp_pkg::coord_type clamp_coord(input wide_type v);
      if (v > 96'sd2147483647) return COORD_MAX;
      if (v < -96'sd2147483648) return COORD_MIN;
      return v[31:0];
   endfunction

   // cordic cosine and sine, quarter mapping, exact rounding, pivot restore
   function automatic rot_point_type rotate_expect(input rot_req_type r);
      longint        x, y, z, xs, ys, c, s, cx, cy, dx, dy;
      wide_type      wdx, wdy, wc, ws, accx, accy;
      rot_point_type res;
      cx = r.use_pivot ? longint'(r.pivot_x) : 64'sd0;
      cy = r.use_pivot ? longint'(r.pivot_y) : 64'sd0;
      x = START_GAIN;
      y = 0;
      z = longint'(r.angle[13:0]) << 16;
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_TAB[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_TAB[i];
         end
      end
      case (rpp_pkg::quarter_type'(r.angle[15:14]))
         rpp_pkg::QUARTER_0: begin c = x;  s = y;  end
         rpp_pkg::QUARTER_1: begin c = -y; s = x;  end
         rpp_pkg::QUARTER_2: begin c = -x; s = -y; end
         default:            begin c = y;  s = -x; end
      endcase
      dx = longint'(r.point_x) - cx;
      dy = longint'(r.point_y) - cy;
      wdx = dx;
      wdy = dy;
      wc = c;
      ws = s;
      accx = ((wdx * wc - wdy * ws + HALF_LSB) >>> 30) + wide_type'(cx);
      accy = ((wdy * wc + wdx * ws + HALF_LSB) >>> 30) + wide_type'(cy);
      res.rotated_x = clamp_coord(accx);
      res.rotated_y = clamp_coord(accy);
      return res;
   endfunction

   function automatic dir_row_type dir_row(input rpp_pkg::coord_type px, py, cx, cy,
                                           input logic up,
                                           input rpp_pkg::angle_type ang, input logic known,
                                           input rpp_pkg::coord_type wx, wy);
      dir_row_type d;
      d.req.point_x   = px;
      d.req.point_y   = py;
      d.req.pivot_x   = cx;
      d.req.pivot_y   = cy;
      d.req.use_pivot = up;
      d.req.angle     = ang;
      d.known         = known;
      d.want.rotated_x = wx;
      d.want.rotated_y = wy;
      return d;
   endfunction

   // coordinates biased toward extremes and small magnitudes
   function automatic rpp_pkg::coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3, 4: return rpp_pkg::coord_type'($urandom_range(0, 32'h1F_FFFF)) - 32'sd1048576;
         default: return rpp_pkg::coord_type'($urandom);
      endcase
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(input rot_req_type r, input rot_point_type want);
      req_bus.valid     <= 1'b1;
      req_bus.point_x   <= r.point_x;
      req_bus.point_y   <= r.point_y;
      req_bus.pivot_x   <= r.pivot_x;
      req_bus.pivot_y   <= r.pivot_y;
      req_bus.use_pivot <= r.use_pivot;
      req_bus.angle     <= r.angle;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      rotated_fifo.push_back(want);
      if (r.use_pivot) pivot_reqs++;
   endtask

   // random idle burst on the request side
   task automatic maybe_idle(input bit allow);
      if (allow && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      while (rotated_fifo.size() != 0) @(posedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // reset and request stimulus
   initial begin
      rot_req_type   r;
      rot_point_type w;
      dir_row_type   d;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.point_x   = '0;
      req_bus.point_y   = '0;
      req_bus.pivot_x   = '0;
      req_bus.pivot_y   = '0;
      req_bus.use_pivot = 1'b0;
      req_bus.angle     = '0;

      directed.push_back(dir_row(0, 0, 0, 0, 1'b0, 16'h0000, 1'b1, 0, 0));
      directed.push_back(dir_row(0, 0, COORD_MAX, COORD_MIN, 1'b0, 16'hFFFF, 1'b1, 0, 0));
      directed.push_back(dir_row(0, 0, 0, 0, 1'b1, 16'h8000, 1'b1, 0, 0));
      directed.push_back(dir_row(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 16'h2000,
                                 1'b1, COORD_MAX, COORD_MIN));
      directed.push_back(dir_row(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 16'hC000,
                                 1'b1, COORD_MIN, COORD_MAX));
      directed.push_back(dir_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 16'h8000,
                                 1'b1, COORD_MIN, COORD_MIN));
      directed.push_back(dir_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 16'h8000,
                                 1'b1, COORD_MAX, COORD_MAX));
      directed.push_back(dir_row(32'sd65536, 0, 0, 0, 1'b0, 16'h0000, 1'b0, 0, 0));
      directed.push_back(dir_row(32'sd65536, 0, 0, 0, 1'b0, 16'h4000, 1'b0, 0, 0));
      directed.push_back(dir_row(32'sd65536, 0, 0, 0, 1'b0, 16'h8000, 1'b0, 0, 0));
      directed.push_back(dir_row(32'sd65536, 0, 0, 0, 1'b0, 16'hC000, 1'b0, 0, 0));
      directed.push_back(dir_row(0, 32'sd65536, 0, 0, 1'b0, 16'h3FFF, 1'b0, 0, 0));
      directed.push_back(dir_row(0, 32'sd65536, 0, 0, 1'b0, 16'hFFFF, 1'b0, 0, 0));
      directed.push_back(dir_row(COORD_MAX, COORD_MAX, 0, 0, 1'b0, 16'h2000, 1'b0, 0, 0));
      directed.push_back(dir_row(COORD_MIN, COORD_MIN, 0, 0, 1'b0, 16'h4000, 1'b0, 0, 0));
      directed.push_back(dir_row(COORD_MIN, COORD_MAX, 0, 0, 1'b0, 16'hFFFF, 1'b0, 0, 0));
      directed.push_back(dir_row(32'sd196608, 32'sd262144, 32'sd65536, 32'sd65536, 1'b1,
                                 16'h4000, 1'b0, 0, 0));
      directed.push_back(dir_row(-32'sd327680, 32'sd458752, -32'sd131072, 32'sd131072, 1'b1,
                                 16'h1234, 1'b0, 0, 0));
      directed.push_back(dir_row(COORD_MAX, 0, COORD_MIN, 0, 1'b1, 16'h0000, 1'b0, 0, 0));
      directed.push_back(dir_row(32'sd1, -32'sd1, COORD_MAX, COORD_MAX, 1'b1, 16'h0001,
                                 1'b0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[k]) begin
         d = directed[k];
         w = d.known ? d.want : rotate_expect(d.req);
         send_request(d.req, w);
         maybe_idle(1'b1);
      end

      // sender pause until the pipeline is empty
      req_bus.valid <= 1'b0;
      drain_results();

      // random requests
      for (int k = 0; k < RAND_ITEMS; k++) begin
         calm = (k >= CALM_FROM);
         if (k == RAND_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            drain_results();
         end
         r.point_x   = rand_coord();
         r.point_y   = rand_coord();
         r.pivot_x   = rand_coord();
         r.pivot_y   = rand_coord();
         r.use_pivot = 1'($urandom_range(0, 1));
         r.angle     = rpp_pkg::angle_type'($urandom);
         send_request(r, rotate_expect(r));
         maybe_idle(!calm && ((k / 200) % 3 != 2));
      end
      req_bus.valid <= 1'b0;

      // wait for the last results, then a margin for strays
      drain_results();
      repeat (TAIL_WAIT) @(posedge clock);
      if (rotated_fifo.size() != 0) errors++;

      $display("covered %0d directed and %0d random requests, %0d about a pivot",
               directed.size(), RAND_ITEMS, pivot_reqs);
      $display("%0d results checked, %0d saturated, random idling and a %0d-cycle output stall",
               results_seen, clipped_seen, LONG_HOLD);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // result side ready: random bursts and one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && !long_done && results_seen >= 60) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_done = 1'b1;
            rsp_bus.ready <= 1'b1;
         end else if (!reset && !calm && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= !reset;
         end
      end
   end

   // compare each result with the oldest pending rotation
   always @(posedge clock) begin
      rot_point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.rotated_x == COORD_MAX || rsp_bus.rotated_x == COORD_MIN ||
             rsp_bus.rotated_y == COORD_MAX || rsp_bus.rotated_y == COORD_MIN)
            clipped_seen++;
         if (rotated_fifo.size() == 0) begin
            if (errors < 10)
               $display("unexpected result x=%0d y=%0d", rsp_bus.rotated_x,
                        rsp_bus.rotated_y);
            errors++;
         end else begin
            want = rotated_fifo.pop_front();
            if (rsp_bus.rotated_x !== want.rotated_x) begin
               if (errors < 10)
                  $display("result %0d rotated_x: expected %0d, got %0d", results_seen,
                           want.rotated_x, rsp_bus.rotated_x);
               errors++;
            end
            if (rsp_bus.rotated_y !== want.rotated_y) begin
               if (errors < 10)
                  $display("result %0d rotated_y: expected %0d, got %0d", results_seen,
                           want.rotated_y, rsp_bus.rotated_y);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rpp_pkg.sv
rtl/core/rpp_if.sv
rtl/core/rpp_cordic.sv
rtl/core/rpp_rotate.sv
rtl/core/rotate_point_about_pivot.sv
rtl/core/rpp_checker.sv
bench/testbench.sv
